FILE: src/tun_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle unit normal package
// Shared constants and types of the triangle unit normal pipeline.
// ---------------------------------------------------------------------------
package tun_pkg;

    localparam int TUN_COORD_WIDTH      = 24;
    localparam int TUN_NORMAL_FRAC_BITS = 30;
    localparam int TUN_OUT_WIDTH        = 32;

    typedef struct packed {
        logic                             deg;
        logic signed [TUN_OUT_WIDTH-1:0]  z;
        logic signed [TUN_OUT_WIDTH-1:0]  y;
        logic signed [TUN_OUT_WIDTH-1:0]  x;
    } t_result;

endpackage

FILE: src/triangle_unit_normal.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle unit normal
// Cross product of two triangle edges, normalized by an integer square
// root and three fractional dividers.
// ---------------------------------------------------------------------------
// The block accepts one triangle per clock cycle while o_s_axis_tready is
// high and returns one normal per triangle, in order. The square root
// resolves one root bit per stage, and the dividers resolve one quotient
// bit per stage. A one-entry skid buffer behind the output register keeps
// the input side accepting while a result waits to be taken, until a second
// result reaches the end of the pipeline and the whole pipeline holds.
module triangle_unit_normal
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH      = TUN_COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = TUN_NORMAL_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, zero fill.
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // normal_x, normal_y, normal_z.
    output logic [3*TUN_OUT_WIDTH-1:0]             o_m_axis_tdata,
    // degenerate.
    output logic                                   o_m_axis_tuser
);

    localparam int W      = COORD_WIDTH;
    localparam int F      = NORMAL_FRAC_BITS;
    localparam int E_W    = W + 1;
    localparam int P_W    = 2 * E_W;
    localparam int M_W    = P_W - 1;
    localparam int LO_W   = (M_W + 1) / 2;
    localparam int HI_W   = M_W - LO_W;
    localparam int HH_W   = 2 * HI_W;
    localparam int HL_W   = HI_W + LO_W;
    localparam int LL_W   = 2 * LO_W;
    localparam int SQ_W   = 2 * M_W;
    localparam int S_W    = 2 * M_W + 2;
    localparam int ROOT_W = S_W / 2;
    localparam int SIDE_W = 3 * M_W + 4;
    localparam int DIV_ST = F + 1;

    logic     r_out_vld;
    t_result  r_out;
    logic     r_skid_vld;
    t_result  r_skid;

    logic w_en;
    assign w_en = !r_skid_vld;
    assign o_s_axis_tready = w_en;

    // Stage A: edges.
    logic                   r_a_vld;
    logic signed [E_W-1:0]  r_a_e1 [3];
    logic signed [E_W-1:0]  r_a_e2 [3];
    // Stage B: products.
    logic                   r_b_vld;
    logic signed [P_W-1:0]  r_b_p [3];
    logic signed [P_W-1:0]  r_b_q [3];
    // Stage C: cross product.
    logic                   r_c_vld;
    logic signed [P_W-1:0]  r_c_c [3];
    // Stage D: sign and magnitude.
    logic                   r_d_vld;
    logic                   r_d_deg;
    logic [2:0]             r_d_sgn;
    logic [M_W-1:0]         r_d_mag [3];
    // Stage E: partial products of the squares.
    logic                   r_e_vld;
    logic                   r_e_deg;
    logic [2:0]             r_e_sgn;
    logic [M_W-1:0]         r_e_mag [3];
    logic [HH_W-1:0]        r_e_hh  [3];
    logic [HL_W-1:0]        r_e_hl  [3];
    logic [LL_W-1:0]        r_e_ll  [3];
    // Stage F: squares.
    logic                   r_f_vld;
    logic                   r_f_deg;
    logic [2:0]             r_f_sgn;
    logic [M_W-1:0]         r_f_mag [3];
    logic [SQ_W-1:0]        r_f_sq  [3];
    // Stage G: sum of squares.
    logic                   r_g_vld;
    logic [S_W-1:0]         r_g_sum;
    logic [SIDE_W-1:0]      r_g_side;

    for (genvar i = 0; i < 3; i++) begin : g_comp
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;
        logic signed [W-1:0] w_v0;
        logic signed [W-1:0] w_v1;
        logic signed [W-1:0] w_v2;
        logic [HI_W-1:0]     w_hi;
        logic [LO_W-1:0]     w_lo;

        assign w_v0 = i_s_axis_tdata[i*W +: W];
        assign w_v1 = i_s_axis_tdata[(3+i)*W +: W];
        assign w_v2 = i_s_axis_tdata[(6+i)*W +: W];
        assign w_hi = r_d_mag[i][M_W-1:LO_W];
        assign w_lo = r_d_mag[i][LO_W-1:0];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_a_e1[i]  <= E_W'(w_v1) - E_W'(w_v0);
                r_a_e2[i]  <= E_W'(w_v2) - E_W'(w_v0);
                r_b_p[i]   <= P_W'(r_a_e1[I1]) * P_W'(r_a_e2[I2]);
                r_b_q[i]   <= P_W'(r_a_e1[I2]) * P_W'(r_a_e2[I1]);
                r_c_c[i]   <= r_b_p[i] - r_b_q[i];
                r_d_sgn[i] <= r_c_c[i][P_W-1];
                r_d_mag[i] <= r_c_c[i][P_W-1] ? M_W'(-r_c_c[i]) : M_W'(r_c_c[i]);
                r_e_sgn[i] <= r_d_sgn[i];
                r_e_mag[i] <= r_d_mag[i];
                r_e_hh[i]  <= HH_W'(w_hi) * HH_W'(w_hi);
                r_e_hl[i]  <= HL_W'(w_hi) * HL_W'(w_lo);
                r_e_ll[i]  <= LL_W'(w_lo) * LL_W'(w_lo);
                r_f_sgn[i] <= r_e_sgn[i];
                r_f_mag[i] <= r_e_mag[i];
                r_f_sq[i]  <= (SQ_W'(r_e_hh[i]) << (2 * LO_W))
                            + (SQ_W'(r_e_hl[i]) << (LO_W + 1))
                            + SQ_W'(r_e_ll[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_deg  <= (r_c_c[0] == '0) && (r_c_c[1] == '0) && (r_c_c[2] == '0);
            r_e_deg  <= r_d_deg;
            r_f_deg  <= r_e_deg;
            r_g_sum  <= S_W'(r_f_sq[0]) + S_W'(r_f_sq[1]) + S_W'(r_f_sq[2]);
            r_g_side <= {r_f_deg, r_f_sgn, r_f_mag[2], r_f_mag[1], r_f_mag[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_axis_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
    end

    // Square root of the sum of squares.
    logic                w_sq_vld;
    logic [ROOT_W-1:0]   w_len;
    logic [SIDE_W-1:0]   w_sq_side;

    tun_isqrt #(
        .RAD_W  (S_W),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_g_vld),
        .i_rad   (r_g_sum),
        .i_side  (r_g_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_len),
        .o_side  (w_sq_side)
    );

    // Three dividers and the tag delay line that runs beside them.
    logic [F:0]  w_quo [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        tun_div #(
            .LEN_W (ROOT_W),
            .FRAC  (F)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_mag ({1'b0, w_sq_side[i*M_W +: M_W]}),
            .i_len (w_len),
            .o_quo (w_quo[i])
        );
    end

    logic        r_dl_vld [DIV_ST];
    logic [3:0]  r_dl_tag [DIV_ST];

    for (genvar k = 0; k < DIV_ST; k++) begin : g_dl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dl_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_dl_vld[k] <= (k == 0) ? w_sq_vld : r_dl_vld[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dl_tag[k] <= (k == 0) ? w_sq_side[SIDE_W-1 -: 4]
                                        : r_dl_tag[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Result assembly, output register and skid buffer.
    t_result  w_res;
    logic     w_end_vld;
    logic     w_deg;
    logic [2:0] w_sgn;

    assign w_end_vld = r_dl_vld[DIV_ST-1];
    assign w_deg     = r_dl_tag[DIV_ST-1][3];
    assign w_sgn     = r_dl_tag[DIV_ST-1][2:0];

    always_comb begin
        w_res.deg = w_deg;
        w_res.x = w_deg ? '0 : (w_sgn[0] ? -TUN_OUT_WIDTH'(w_quo[0]) : TUN_OUT_WIDTH'(w_quo[0]));
        w_res.y = w_deg ? '0 : (w_sgn[1] ? -TUN_OUT_WIDTH'(w_quo[1]) : TUN_OUT_WIDTH'(w_quo[1]));
        w_res.z = w_deg ? '0 : (w_sgn[2] ? -TUN_OUT_WIDTH'(w_quo[2]) : TUN_OUT_WIDTH'(w_quo[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_m_axis_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_end_vld;
                r_out      <= w_res;
            end
        end else if (w_en && w_end_vld) begin
            r_skid_vld <= 1'b1;
            r_skid     <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out.z, r_out.y, r_out.x};
    assign o_m_axis_tuser  = r_out.deg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid buffer holds a result while the output register is empty");

    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_axis_tready && w_en && w_end_vld) |=> r_skid_vld)
        else $error("result leaving the pipeline during a stall was dropped");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("degenerate result carries a nonzero normal");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_g_vld) && $stable(r_dl_vld[DIV_ST-1])))
        else $error("pipeline moved while stalled");
`endif

endmodule

FILE: src/tun_isqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Produces one root bit per register stage and carries a sideband word
// and a valid bit along with each radicand.
// ---------------------------------------------------------------------------
module tun_isqrt
    import tun_pkg::*;
#(
    parameter int RAD_W  = 4 * TUN_COORD_WIDTH + 4,
    parameter int SIDE_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [RAD_W-1:0]      i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_vld,
    output logic [RAD_W/2-1:0]    o_root,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int ROOT_W = RAD_W / 2;

    logic                r_vld  [ROOT_W];
    logic [ROOT_W:0]     r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [RAD_W-1:0]    r_rad  [ROOT_W];
    logic [SIDE_W-1:0]   r_side [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic                a_vld;
        logic [ROOT_W:0]     a_rem;
        logic [ROOT_W-1:0]   a_root;
        logic [RAD_W-1:0]    a_rad;
        logic [SIDE_W-1:0]   a_side;
        logic [ROOT_W+1:0]   w_rem2;
        logic [ROOT_W+1:0]   w_trial;
        logic [ROOT_W+1:0]   w_diff;
        logic                w_ge;

        if (k == 0) begin : g_first
            assign a_vld  = i_vld;
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_rad  = i_rad;
            assign a_side = i_side;
        end else begin : g_next
            assign a_vld  = r_vld[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_root = r_root[k-1];
            assign a_rad  = r_rad[k-1];
            assign a_side = r_side[k-1];
        end

        assign w_rem2  = {a_rem[ROOT_W-1:0], a_rad[RAD_W-1 -: 2]};
        assign w_trial = {a_root, 2'b01};
        assign w_ge    = (w_rem2 >= w_trial);
        assign w_diff  = w_ge ? (w_rem2 - w_trial) : w_rem2;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_diff[ROOT_W:0];
                r_root[k] <= {a_root[ROOT_W-2:0], w_ge};
                r_rad[k]  <= {a_rad[RAD_W-3:0], 2'b00};
                r_side[k] <= a_side;
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

FILE: src/tun_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined fractional divider
// Computes floor(mag * 2^FRAC / len) for mag <= len, one quotient bit
// per register stage by restoring division.
// ---------------------------------------------------------------------------
module tun_div
    import tun_pkg::*;
#(
    parameter int LEN_W = 2 * TUN_COORD_WIDTH + 2,
    parameter int FRAC  = TUN_NORMAL_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [LEN_W-1:0]   i_mag,
    input  logic [LEN_W-1:0]   i_len,
    output logic [FRAC:0]      o_quo
);

    localparam int STAGES = FRAC + 1;

    logic [LEN_W:0]     r_rem [STAGES];
    logic [LEN_W-1:0]   r_len [STAGES];
    logic [FRAC:0]      r_quo [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [LEN_W:0]     a_rem;
        logic [LEN_W-1:0]   a_len;
        logic [FRAC:0]      a_quo;
        logic [LEN_W:0]     w_diff;
        logic               w_ge;

        if (k == 0) begin : g_first
            assign a_rem = {1'b0, i_mag};
            assign a_len = i_len;
            assign a_quo = '0;
        end else begin : g_next
            assign a_rem = r_rem[k-1];
            assign a_len = r_len[k-1];
            assign a_quo = r_quo[k-1];
        end

        assign w_ge   = (a_rem >= {1'b0, a_len});
        assign w_diff = w_ge ? (a_rem - {1'b0, a_len}) : a_rem;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= {w_diff[LEN_W-1:0], 1'b0};
                r_len[k] <= a_len;
                r_quo[k] <= {a_quo[FRAC-1:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[STAGES-1];

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle unit normal testbench
// Feeds triangles through the stream input with random gaps and output
// stalls, predicts each unit normal with exact wide arithmetic and checks
// every output transaction field by field, in order.
// ---------------------------------------------------------------------------
module tb;
    import tun_pkg::*;

    localparam int CW = TUN_COORD_WIDTH;
    localparam int FB = TUN_NORMAL_FRAC_BITS;
    localparam int DW = ((9*CW+7)/8)*8;
    localparam int N_RANDOM = 1400;
    localparam int LATENCY = 8 + (2*CW + 2) + (FB + 1);
    localparam longint MAX_CYCLES = 2000000;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef logic signed [CW-1:0] t_coord;
    typedef struct {
        t_coord v[9];
    } t_tri;
    typedef struct {
        t_tri   vtx;
        logic   known;
        t_result res;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [3*TUN_OUT_WIDTH-1:0] m_tdata;
    logic          m_tuser;

    t_result normal_queue[$];
    longint  cycle_count = 0;
    int      error_count = 0;
    int      normals_seen = 0;
    int      degenerate_seen = 0;
    bit      stim_done = 1'b0;

    triangle_unit_normal i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [DW-1:0] pack_tri(t_tri t);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*CW +: CW] = t.v[i];
        return d;
    endfunction

    function automatic t_result unit_normal(t_tri t);
        logic signed [159:0] e1[3], e2[3], c[3], sum, len, cand, mag, num;
        logic [31:0] q, trial;
        t_result r;
        for (int i = 0; i < 3; i++) begin
            e1[i] = 160'(t.v[3+i]) - 160'(t.v[i]);
            e2[i] = 160'(t.v[6+i]) - 160'(t.v[i]);
        end
        c[0] = e1[1]*e2[2] - e1[2]*e2[1];
        c[1] = e1[2]*e2[0] - e1[0]*e2[2];
        c[2] = e1[0]*e2[1] - e1[1]*e2[0];
        sum = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
        r = '0;
        if (sum == 0) begin
            r.deg = 1'b1;
            return r;
        end
        len = 0;
        for (int b = 67; b >= 0; b--) begin
            cand = len | (160'sd1 <<< b);
            if (cand*cand <= sum) len = cand;
        end
        for (int i = 0; i < 3; i++) begin
            mag = (c[i] < 0) ? -c[i] : c[i];
            num = mag <<< FB;
            q = 0;
            for (int b = FB; b >= 0; b--) begin
                trial = q | (32'd1 << b);
                if (160'(trial) * len <= num) q = trial;
            end
            if (c[i] < 0) q = -q;
            case (i)
                0: r.x = q;
                1: r.y = q;
                default: r.z = q;
            endcase
        end
        return r;
    endfunction

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 8191)) - 4096;
            2: return ($urandom_range(0, 1)) ? CMAX : CMIN;
            default: return t_coord'($urandom_range(0, 255)) - 128;
        endcase
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        int mode;
        int kind;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++) t.v[i] = rand_coord(mode);
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
        end else if (kind == 1) begin
            // Collinear: third vertex is v0 + 2 * (v1 - v0) in small range.
            for (int i = 0; i < 9; i++) t.v[i] = rand_coord(3);
            for (int i = 0; i < 3; i++) t.v[6+i] = 2*t.v[3+i] - t.v[i];
        end
        return t;
    endfunction

    task automatic send_tri(t_tri t, logic known, t_result res);
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(5, 40)
                                                 : $urandom_range(1, 3))
                @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_tri(t);
        normal_queue.push_back(known ? res : unit_normal(t));
        if (known && unit_normal(t) != res) begin
            $error("table row disagrees with predictor");
            error_count++;
        end
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    function automatic t_tri tri_of(t_coord a[9]);
        t_tri t;
        for (int i = 0; i < 9; i++) t.v[i] = a[i];
        return t;
    endfunction

    localparam logic signed [31:0] ONE = 32'sd1 <<< FB;
    t_row directed[$];

    initial begin
        t_coord a[9];
        t_result r;
        // Right triangle in the xy plane: normal +z.
        a = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        r = '0; r.z = ONE;
        directed.push_back('{tri_of(a), 1'b1, r});
        // Reversed winding: normal -z.
        a = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};
        r = '0; r.z = -ONE;
        directed.push_back('{tri_of(a), 1'b1, r});
        // yz plane: normal +x.
        a = '{0, 0, 0, 0, 1, 0, 0, 0, 1};
        r = '0; r.x = ONE;
        directed.push_back('{tri_of(a), 1'b1, r});
        // zx plane: normal +y.
        a = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
        r = '0; r.y = ONE;
        directed.push_back('{tri_of(a), 1'b1, r});
        // Coincident vertices, all zero and all extremes: degenerate.
        r = '0; r.deg = 1'b1;
        a = '{default: 0};
        directed.push_back('{tri_of(a), 1'b1, r});
        a = '{default: CMAX};
        directed.push_back('{tri_of(a), 1'b1, r});
        a = '{default: CMIN};
        directed.push_back('{tri_of(a), 1'b1, r});
        // Collinear vertices on a line.
        a = '{CMIN, CMIN, CMIN, 0, 0, 0, CMAX, CMAX, CMAX};
        directed.push_back('{tri_of(a), 1'b1, r});
        // Extreme edges and small triangles, predicted.
        a = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN};
        directed.push_back('{tri_of(a), 1'b0, r});
        a = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN};
        directed.push_back('{tri_of(a), 1'b0, r});
        a = '{CMIN, CMAX, 0, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX};
        directed.push_back('{tri_of(a), 1'b0, r});
        a = '{0, 0, 0, 1, 0, 0, 0, 1, 1};
        directed.push_back('{tri_of(a), 1'b0, r});
        a = '{0, 0, 0, 1, 1, 1, -1, 1, 0};
        directed.push_back('{tri_of(a), 1'b0, r});
        a = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        directed.push_back('{tri_of(a), 1'b0, r});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send_tri(directed[i].vtx, directed[i].known,
                                       directed[i].res);
        for (int n = 0; n < N_RANDOM; n++) send_tri(rand_tri(), 1'b0, r);
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($urandom_range(0, 99) < 70 || (cycle_count / 3000) % 2 == 1)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 20) == 0) ? 1'b0
                          : ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.x = m_tdata[0 +: 32];
            got.y = m_tdata[32 +: 32];
            got.z = m_tdata[64 +: 32];
            got.deg = m_tuser;
            if (normal_queue.size() == 0) begin
                $error("output transaction with no triangle pending");
                error_count++;
            end else begin
                want = normal_queue.pop_front();
                normals_seen++;
                if (want.deg) degenerate_seen++;
                if (got.x !== want.x) begin
                    $error("normal_x: expected %0d, got %0d", want.x, got.x);
                    error_count++;
                end
                if (got.y !== want.y) begin
                    $error("normal_y: expected %0d, got %0d", want.y, got.y);
                    error_count++;
                end
                if (got.z !== want.z) begin
                    $error("normal_z: expected %0d, got %0d", want.z, got.z);
                    error_count++;
                end
                if (got.deg !== want.deg) begin
                    $error("degenerate: expected %0b, got %0b", want.deg, got.deg);
                    error_count++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (normal_queue.size() != 0 && cycle_count < MAX_CYCLES)
            @(posedge i_clk);
        repeat (2*LATENCY) @(posedge i_clk);
        $display("Covered %0d normals, %0d of them degenerate, with random gaps and stalls.",
                 normals_seen, degenerate_seen);
        if (error_count == 0 && normal_queue.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES) begin
            $display("Timed out with %0d normals outstanding.", normal_queue.size());
            $display("tb: done, errors");
            $finish;
        end
    end
endmodule
